// ===== src/sfm_pkg.sv =====
package sfm_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   // input action codes
   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic append;
      logic start;
      logic rd_k;
      logic latch_k;
      logic scan;
      logic eval_best;
      logic next_k;
      logic reload_k;
      logic load_mode;
      logic load_empty;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic count_zero;
      logic j_last;
      logic k_zero;
      logic match;
      logic out_free;
   } status_type;

endpackage

// ===== src/sfm_ram.sv =====
module sfm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sfm_ctrl.sv =====
module sfm_ctrl
   import sfm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      EMPTY,
      RD_K,
      LATCH_K,
      SCAN,
      DRAIN,
      EVAL,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      accept;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               if (req_action == ACT_APPEND) begin
                  cmd.append = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  pass_in   = 1'b0;
                  state_in  = status.count_zero ? EMPTY : RD_K;
               end
            end
         end
         EMPTY: begin
            if (status.out_free) begin
               cmd.load_empty = 1'b1;
               state_in       = IDLE;
            end
         end
         RD_K: begin
            cmd.rd_k = 1'b1;
            state_in = LATCH_K;
         end
         LATCH_K: begin
            cmd.latch_k = 1'b1;
            state_in    = SCAN;
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (status.j_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = EVAL;
         end
         EVAL: begin
            if (!pass_ff) begin
               cmd.eval_best = 1'b1;
               state_in      = RD_K;
               if (status.k_zero) begin
                  cmd.reload_k = 1'b1;
                  pass_in      = 1'b1;
               end else begin
                  cmd.next_k = 1'b1;
               end
            end else if (status.match) begin
               state_in = EMIT;
            end else if (status.k_zero) begin
               state_in = IDLE;
            end else begin
               cmd.next_k = 1'b1;
               state_in   = RD_K;
            end
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.load_mode = 1'b1;
               if (status.k_zero) begin
                  state_in = IDLE;
               end else begin
                  cmd.next_k = 1'b1;
                  state_in   = RD_K;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

`ifndef SYNTHESIS
   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_mode || cmd.load_empty) |-> status.out_free)
      else $error("result loaded while output register busy");
`endif

endmodule

// ===== src/sfm_datapath.sv =====
module sfm_datapath
   import sfm_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_mode_value,
   output logic [COUNT_W-1:0]        rsp_mode_count,
   output logic                      rsp_is_last,
   output logic                      rsp_set_empty,
   output logic                      rsp_overflowed
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0]      count_ff, n_ff, cnt_ff, best_ff, total_ff, emitted_ff;
   logic               ovf_ff, ovf_hold_ff, newest_ff;
   logic [AW-1:0]      k_ff, j_ff, cmp_idx_ff, rd_addr;
   logic               cmp_en_ff;
   logic [VALUE_W-1:0] vk_ff, rd_data;
   logic               wr_en, full, eq;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_mode_value_ff;
   logic [COUNT_W-1:0]        rsp_mode_count_ff;
   logic                      rsp_is_last_ff, rsp_set_empty_ff, rsp_overflowed_ff;

   assign full    = (count_ff >= CW'(MAX_ITEMS));
   assign wr_en   = cmd.append && !full;
   assign rd_addr = cmd.rd_k ? k_ff : j_ff;
   assign eq      = (rd_data == vk_ff);

   sfm_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_ITEMS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         n_ff         <= '0;
         best_ff      <= '0;
         total_ff     <= '0;
         emitted_ff   <= '0;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.append) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= CW'(count_ff + 1'b1);
            end
         end
         if (cmd.start) begin
            n_ff       <= count_ff;
            best_ff    <= '0;
            total_ff   <= '0;
            emitted_ff <= '0;
            count_ff   <= '0;
            ovf_ff     <= 1'b0;
         end
         // best count over newest occurrences, and how many reach it
         if (cmd.eval_best && newest_ff) begin
            if (cnt_ff > best_ff) begin
               best_ff  <= cnt_ff;
               total_ff <= CW'(1);
            end else if (cnt_ff == best_ff) begin
               total_ff <= CW'(total_ff + 1'b1);
            end
         end
         if (cmd.load_mode) begin
            emitted_ff <= CW'(emitted_ff + 1'b1);
         end
         cmp_en_ff <= cmd.scan;
         if (cmd.load_mode || cmd.load_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ovf_hold_ff <= ovf_ff;
         k_ff        <= AW'(count_ff - 1'b1);
      end else if (cmd.reload_k) begin
         k_ff <= AW'(n_ff - 1'b1);
      end else if (cmd.next_k) begin
         k_ff <= AW'(k_ff - 1'b1);
      end
      if (cmd.latch_k) begin
         vk_ff     <= rd_data;
         cnt_ff    <= '0;
         newest_ff <= 1'b1;
         j_ff      <= '0;
      end else begin
         if (cmd.scan) begin
            j_ff <= AW'(j_ff + 1'b1);
         end
         // compare the word read last cycle against the held entry
         if (cmp_en_ff && eq) begin
            cnt_ff <= CW'(cnt_ff + 1'b1);
            if (cmp_idx_ff > k_ff) begin
               newest_ff <= 1'b0;
            end
         end
      end
      cmp_idx_ff <= j_ff;
      if (cmd.load_mode) begin
         rsp_mode_value_ff <= vk_ff;
         rsp_mode_count_ff <= COUNT_W'(best_ff);
         rsp_is_last_ff    <= (CW'(emitted_ff + 1'b1) == total_ff);
         rsp_set_empty_ff  <= 1'b0;
         rsp_overflowed_ff <= ovf_hold_ff;
      end else if (cmd.load_empty) begin
         rsp_mode_value_ff <= '0;
         rsp_mode_count_ff <= '0;
         rsp_is_last_ff    <= 1'b1;
         rsp_set_empty_ff  <= 1'b1;
         rsp_overflowed_ff <= ovf_hold_ff;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.j_last     = (j_ff == AW'(n_ff - 1'b1));
   assign status.k_zero     = (k_ff == '0);
   assign status.match      = newest_ff && (cnt_ff == best_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_value = rsp_mode_value_ff;
   assign rsp_mode_count = rsp_mode_count_ff;
   assign rsp_is_last    = rsp_is_last_ff;
   assign rsp_set_empty  = rsp_set_empty_ff;
   assign rsp_overflowed = rsp_overflowed_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("stored count beyond capacity");
   a_best_le_n: assert property (@(posedge clock) disable iff (reset)
      best_ff <= n_ff)
      else $error("best count exceeds scanned length");
   a_mode_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_set_empty_ff) |-> (rsp_mode_count_ff != '0))
      else $error("mode result with zero count");
`endif

endmodule

// ===== src/sequence_mode_finder_core.sv =====
// append word: accepted without stalling the input, gives no result
// finish word: two passes over the n stored values, each entry read, latched and scanned
//   against all n (one store read port, one compare a cycle); the second pass emits results
// empty finish: single result loaded in the EMPTY state after accept; input stalled until it is loaded
// reset (synchronous, active high) clears the stored count, the overflow flag, the
//   controller and the output valid; the store contents are left as they are
module sequence_mode_finder_core
   import sfm_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_mode_value,
   output logic [COUNT_W-1:0]        rsp_mode_count,
   output logic                      rsp_is_last,
   output logic                      rsp_set_empty,
   output logic                      rsp_overflowed
);

   // controller sequences the pairwise walk, datapath holds store and counters
   cmd_type    cmd;
   status_type status;

   // controller: idle, empty result, then per entry read, latch, scan, drain, evaluate, emit
   sfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_action(req_action),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: value store, occurrence counter, best and tie tally, output register
   sfm_datapath #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_mode_value(rsp_mode_value),
      .rsp_mode_count(rsp_mode_count),
      .rsp_is_last   (rsp_is_last),
      .rsp_set_empty (rsp_set_empty),
      .rsp_overflowed(rsp_overflowed)
   );

endmodule
